// ===== hdl/tick_task_scheduler_assert.svh =====
// Assertion macros shared by the tick task scheduler.
`ifndef TICK_TASK_SCHEDULER_ASSERT_SVH
`define TICK_TASK_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/tts_pkg.sv =====
// Types and constants of the tick task scheduler.
package tts_pkg;

	localparam int SLOTS = 16;
	localparam int MAX_RESULTS = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	localparam logic CMD_REGISTER = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic KIND_REG = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK = 2'd0,
		STAT_TAKEN = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_DIV,
		S_FINISH
	} sched_state_t;

	typedef struct packed {
		logic [15:0] delay;
		logic [15:0] period;
	} entry_t;

endpackage

// ===== hdl/tick_task_scheduler.sv =====
// Tick task scheduler: slot table in a synchronous memory, walked once per tick.
//
// One command channel: a word is taken when start is high and busy is low.
// A register word (command 0) claims a slot and gives one status result on
// the cycle after it is taken; busy stays low, so a new word may follow.
// A tick word (command 1) raises busy while the slots are walked in order,
// each slot read from memory and then evaluated. A taken slot with an action
// whose delay is spent and whose period is non-zero then runs a bit-serial
// remainder of the 32-bit tick count by its period, and fires when that
// remainder is zero.
// Firing results leave one per strobe, lowest slot first, the final one
// with last set; a tick that fires nothing gives a single result with
// fired low. Each result is on the ports for one cycle, marked by strobe;
// the receiver cannot stall, and none is needed.
// Reset clears the taken and action flags and the tick count; the delay and
// period memory needs no clearing, as an entry is used only once written.
`include "tick_task_scheduler_assert.svh"

module tick_task_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [5:0]  slot,
	input  logic [15:0] init_delay,
	input  logic [15:0] period,
	input  logic        has_action,
	output logic        strobe,
	output logic        kind,
	output logic [1:0]  status,
	output logic        fired,
	output logic [5:0]  fired_slot,
	output logic        last
);
	import tts_pkg::*;

	sched_state_t state_q, state_d;

	logic [SLOTS-1:0] taken_q;
	logic [SLOTS-1:0] active_q;
	entry_t mem [SLOTS];
	entry_t rdata_q;
	logic mem_we;
	logic [SLOT_W-1:0] mem_wa;
	entry_t mem_wd;

	logic [31:0] tick_q;
	logic [SLOT_W-1:0] idx_q;
	logic [15:0] rem_q;
	logic [15:0] per_q;
	logic [4:0] bit_q;
	logic pend_q;
	logic [5:0] pend_slot_q;
	logic [CNT_W-1:0] cnt_q;

	logic strobe_q, kind_q, fired_q, last_q;
	status_t status_q;
	logic [5:0] fslot_q;

	logic accept, reg_accept, in_range, slot_live, last_idx, go_next, emit_hit;
	logic [SLOT_W-1:0] slot_idx;
	logic [16:0] rem_sh, rem_nx;

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign reg_accept = accept && (command == CMD_REGISTER);
	assign in_range = ({1'b0, slot} < 7'(SLOTS));
	assign slot_idx = slot[SLOT_W-1:0];
	assign slot_live = taken_q[idx_q] && active_q[idx_q];
	assign last_idx = (idx_q == SLOT_W'(SLOTS - 1));

	assign rem_sh = {rem_q, tick_q[bit_q]};
	assign rem_nx = (rem_sh >= {1'b0, per_q}) ? (rem_sh - {1'b0, per_q}) : rem_sh;

	always_comb begin
		state_d = state_q;
		go_next = 1'b0;
		emit_hit = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept && (command == CMD_TICK))
					state_d = S_READ;
			end
			S_READ: state_d = S_EVAL;
			S_EVAL: begin
				if (slot_live && (rdata_q.delay == 16'd0) && (rdata_q.period != 16'd0))
					state_d = S_DIV;
				else
					go_next = 1'b1;
			end
			S_DIV: begin
				if (bit_q == 5'd0) begin
					go_next = 1'b1;
					emit_hit = (rem_nx == 17'd0);
				end
			end
			S_FINISH: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		if (go_next)
			state_d = last_idx ? S_FINISH : S_READ;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = rdata_q;
		if (reg_accept && in_range && !taken_q[slot_idx]) begin
			mem_we = 1'b1;
			mem_wa = slot_idx;
			mem_wd.delay = init_delay;
			mem_wd.period = period;
		end else if ((state_q == S_EVAL) && slot_live && (rdata_q.delay != 16'd0)) begin
			mem_we = 1'b1;
			mem_wd.delay = rdata_q.delay - 16'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rdata_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
			active_q <= '0;
			tick_q <= '0;
			idx_q <= '0;
			pend_q <= 1'b0;
			cnt_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= reg_accept || (state_q == S_FINISH) ||
				(emit_hit && (cnt_q < CNT_W'(MAX_RESULTS)) && pend_q);
			if (reg_accept && in_range && !taken_q[slot_idx]) begin
				taken_q[slot_idx] <= 1'b1;
				active_q[slot_idx] <= has_action;
			end
			if (accept && (command == CMD_TICK)) begin
				tick_q <= tick_q + 32'd1;
				idx_q <= '0;
				pend_q <= 1'b0;
				cnt_q <= '0;
			end
			if (go_next && !last_idx)
				idx_q <= idx_q + SLOT_W'(1);
			if (emit_hit && (cnt_q < CNT_W'(MAX_RESULTS))) begin
				pend_q <= 1'b1;
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EVAL) begin
			rem_q <= 16'd0;
			per_q <= rdata_q.period;
			bit_q <= 5'd31;
		end else if (state_q == S_DIV) begin
			rem_q <= rem_nx[15:0];
			bit_q <= bit_q - 5'd1;
		end

		if (reg_accept) begin
			kind_q <= KIND_REG;
			fired_q <= 1'b0;
			fslot_q <= 6'd0;
			last_q <= 1'b1;
			if (!in_range)
				status_q <= STAT_RANGE;
			else if (taken_q[slot_idx])
				status_q <= STAT_TAKEN;
			else
				status_q <= STAT_OK;
		end else if (emit_hit && (cnt_q < CNT_W'(MAX_RESULTS))) begin
			pend_slot_q <= 6'(idx_q);
			kind_q <= KIND_TICK;
			status_q <= STAT_OK;
			fired_q <= 1'b1;
			fslot_q <= pend_slot_q;
			last_q <= 1'b0;
		end else if (state_q == S_FINISH) begin
			kind_q <= KIND_TICK;
			status_q <= STAT_OK;
			fired_q <= pend_q;
			fslot_q <= pend_q ? pend_slot_q : 6'd0;
			last_q <= 1'b1;
		end
	end

	assign strobe = strobe_q;
	assign kind = kind_q;
	assign status = status_q;
	assign fired = fired_q;
	assign fired_slot = fslot_q;
	assign last = last_q;

	`TTS_ASSERT_NEXT(a_reg_result, reg_accept, strobe && (kind == KIND_REG) && last && !fired,
		"Registration word did not give a single status result")
	`TTS_ASSERT_NOW(a_quiet_is_last, strobe && !fired, last,
		"A result without a firing was not marked last")
	`TTS_ASSERT_NOW(a_div_period, state_q == S_DIV, per_q != 16'd0,
		"Remainder unit running with a zero period")
	`TTS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_RESULTS),
		"More firings counted than may be reported")
	`TTS_ASSERT_NOW(a_tick_result_busy, strobe && (kind == KIND_TICK) && !last, busy,
		"A firing result that is not last appeared after the walk ended")

endmodule

// ===== tb/sv/tick_task_scheduler_tb.sv =====
// Self-checking testbench for the tick task scheduler, with directed and random words.
module tick_task_scheduler_tb;
	import tts_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 600;

	typedef struct packed {
		logic        kind;
		status_t     status;
		logic        fired;
		logic [5:0]  fired_slot;
		logic        last;
	} report_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        command;
	logic [5:0]  slot;
	logic [15:0] init_delay;
	logic [15:0] period;
	logic        has_action;
	logic        strobe;
	logic        kind;
	logic [1:0]  status;
	logic        fired;
	logic [5:0]  fired_slot;
	logic        last;

	logic        slot_used [SLOTS];
	logic        slot_runs [SLOTS];
	logic [15:0] wait_ticks [SLOTS];
	logic [15:0] repeat_ticks [SLOTS];
	logic [31:0] tick_total;

	report_t     due_reports [$];
	report_t     want;
	int          idle_pct = 0;
	int          mismatches = 0;
	int          cycle_count = 0;
	int          register_words = 0;
	int          tick_words = 0;
	int          quiet_ticks = 0;
	int          firings_checked = 0;

	tick_task_scheduler uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.slot(slot),
		.init_delay(init_delay),
		.period(period),
		.has_action(has_action),
		.strobe(strobe),
		.kind(kind),
		.status(status),
		.fired(fired),
		.fired_slot(fired_slot),
		.last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.",
				cycle_count, due_reports.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("Mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	function automatic void apply_word(input logic cmd, input logic [5:0] sl,
		input logic [15:0] dly, input logic [15:0] per, input logic act);
		status_t st;
		report_t held;
		bit      have_held;
		int      n;
		have_held = 0;
		n = 0;
		if (cmd == CMD_REGISTER) begin
			register_words++;
			if (sl >= SLOTS) begin
				st = STAT_RANGE;
			end else if (slot_used[sl]) begin
				st = STAT_TAKEN;
			end else begin
				slot_used[sl] = 1'b1;
				slot_runs[sl] = act;
				wait_ticks[sl] = dly;
				repeat_ticks[sl] = per;
				st = STAT_OK;
			end
			due_reports.push_back('{KIND_REG, st, 1'b0, 6'd0, 1'b1});
			return;
		end
		tick_words++;
		tick_total = tick_total + 32'd1;
		for (int i = 0; i < SLOTS; i++) begin
			if (!slot_used[i] || !slot_runs[i])
				continue;
			if (wait_ticks[i] != 16'd0) begin
				wait_ticks[i] = wait_ticks[i] - 16'd1;
			end else if (repeat_ticks[i] != 16'd0 &&
				(tick_total % {16'd0, repeat_ticks[i]}) == 32'd0) begin
				if (n < MAX_RESULTS) begin
					if (have_held)
						due_reports.push_back(held);
					held = '{KIND_TICK, STAT_OK, 1'b1, 6'(i), 1'b0};
					have_held = 1;
					n++;
				end
			end
		end
		if (have_held) begin
			held.last = 1'b1;
			due_reports.push_back(held);
		end else begin
			quiet_ticks++;
			due_reports.push_back('{KIND_TICK, STAT_OK, 1'b0, 6'd0, 1'b1});
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (due_reports.size() == 0) begin
				flag_mismatch($sformatf("result with nothing expected (kind %0b slot %0d)",
					kind, fired_slot));
			end else begin
				want = due_reports.pop_front();
				if (want.fired)
					firings_checked++;
				if (kind !== want.kind)
					flag_mismatch($sformatf("kind %0b, expected %0b", kind, want.kind));
				if (status !== want.status)
					flag_mismatch($sformatf("status %0d, expected %0d", status, want.status));
				if (fired !== want.fired)
					flag_mismatch($sformatf("fired %0b, expected %0b", fired, want.fired));
				if (fired_slot !== want.fired_slot)
					flag_mismatch($sformatf("fired_slot %0d, expected %0d",
						fired_slot, want.fired_slot));
				if (last !== want.last)
					flag_mismatch($sformatf("last %0b, expected %0b", last, want.last));
			end
		end
	end

	task automatic send_word(input logic cmd, input logic [5:0] sl,
		input logic [15:0] dly, input logic [15:0] per, input logic act);
		start <= 1'b1;
		command <= cmd;
		slot <= sl;
		init_delay <= dly;
		period <= per;
		has_action <= act;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		apply_word(cmd, sl, dly, per, act);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (due_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_quiet_tick();
		send_word(CMD_TICK, 6'd0, 16'd0, 16'd0, 1'b0);
	endtask

	task automatic test_slot_range();
		send_word(CMD_REGISTER, 6'd63, 16'd1, 16'd1, 1'b1);
		send_word(CMD_REGISTER, 6'(SLOTS), 16'd0, 16'd1, 1'b1);
	endtask

	task automatic test_taken_and_skipped();
		send_word(CMD_REGISTER, 6'd0, 16'd0, 16'd0, 1'b1);
		send_word(CMD_REGISTER, 6'd0, 16'd5, 16'd2, 1'b1);
		send_word(CMD_REGISTER, 6'd1, 16'd0, 16'd1, 1'b0);
		send_word(CMD_TICK, 6'd63, 16'hFFFF, 16'hFFFF, 1'b1);
		send_word(CMD_TICK, 6'd1, 16'd0, 16'd1, 1'b0);
	endtask

	task automatic test_delay_expiry();
		send_word(CMD_REGISTER, 6'd15, 16'd2, 16'd3, 1'b1);
		repeat (6)
			send_word(CMD_TICK, 6'd0, 16'd0, 16'd0, 1'b0);
	endtask

	task automatic test_field_extremes();
		send_word(CMD_REGISTER, 6'd14, 16'hFFFF, 16'hFFFF, 1'b1);
		send_word(CMD_TICK, 6'd0, 16'd0, 16'd0, 1'b0);
		wait_drained();
	endtask

	task automatic test_random(input int pct, input int count);
		logic [5:0]  sl;
		logic [15:0] dly;
		logic [15:0] per;
		logic        act;
		idle_pct = pct;
		for (int k = 0; k < count; k++) begin
			sl = 6'($urandom_range(63));
			dly = 16'($urandom);
			per = 16'($urandom);
			act = 1'($urandom);
			if ($urandom_range(99) < 20) begin
				if ($urandom_range(99) < 80)
					sl = 6'($urandom_range(SLOTS - 1));
				if ($urandom_range(99) < 85)
					dly = 16'($urandom_range(6));
				case ($urandom_range(9))
				0: per = 16'd0;
				1: ;
				default: per = 16'($urandom_range(8, 1));
				endcase
				if ($urandom_range(99) < 85)
					act = 1'b1;
				send_word(CMD_REGISTER, sl, dly, per, act);
			end else begin
				send_word(CMD_TICK, sl, dly, per, act);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_runs[i] = 1'b0;
			wait_ticks[i] = 16'd0;
			repeat_ticks[i] = 16'd0;
		end
		tick_total = 32'd0;
		arst_n <= 1'b0;
		start <= 1'b0;
		command <= CMD_REGISTER;
		slot <= 6'd0;
		init_delay <= 16'd0;
		period <= 16'd0;
		has_action <= 1'b0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		test_quiet_tick();
		test_slot_range();
		test_taken_and_skipped();
		test_delay_expiry();
		test_field_extremes();
		test_random(0, 104);
		wait_drained();
		test_random(72, 103);
		wait_drained();
		test_random(17, 103);
		wait_drained();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		$display("Sent %0d registrations and %0d ticks, %0d of them quiet.",
			register_words, tick_words, quiet_ticks);
		$display("Checked %0d firing reports over %0d cycles; %0d mismatches.",
			firings_checked, cycle_count, mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
